@@ src/tpqrc_pkg.sv @@
// Shared types and constants for the two-pass quantiser rate controller.
// Used by tpqrc_ctrl, tpqrc_dp and two_pass_quantizer_rate_control_top.
package tpqrc_pkg;

  localparam int unsigned WARMUP_FRAMES_DEF = 20;

  localparam int unsigned TOT_W   = 56;
  localparam int unsigned NUM_W   = 46;
  localparam int unsigned DQ_W    = 17;
  localparam int unsigned Q18_W   = 24;
  localparam int unsigned Q34_W   = 41;
  localparam int unsigned CNT_W   = 6;

  localparam logic [CNT_W-1:0] DIV1_LAST = CNT_W'(NUM_W - 1);
  localparam logic [CNT_W-1:0] DIV2_LAST = CNT_W'(16);

  localparam logic [DQ_W-1:0] DQ_MIN = 17'd39322;
  localparam logic [DQ_W-1:0] DQ_MAX = 17'd98304;
  localparam logic [DQ_W-1:0] DQ_ONE = 17'd65536;

  localparam logic [14:0] BASE_QUANT_RST   = 15'd4096;
  localparam logic [23:0] TOTAL_FRAMES_RST = 24'd1;

  localparam logic REG_BASE_QUANT   = 1'b0;
  localparam logic REG_TOTAL_FRAMES = 1'b1;

  typedef struct packed {
    logic [30:0] coded_bits;
    logic [30:0] first_pass_texture_bits;
    logic [30:0] first_pass_other_bits;
    logic [4:0]  first_pass_quant;
    logic [8:0]  next_multiplier;
    logic [3:0]  dither;
  } in_word_t;

  typedef struct packed {
    logic [4:0] quantizer;
    logic       past_end;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DINIT1, S_DIV1, S_ACC, S_DQSEL, S_DIV2,
    S_SQ, S_CLAMP, S_MUL2, S_ROUND, S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic mul1;
    logic div1_init;
    logic div_step;
    logic div_shift;
    logic acc;
    logic dq_fixed;
    logic div2_init;
    logic sq;
    logic clamp;
    logic mul2;
    logic round;
    logic set_past;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic past_end;
    logic skip_div;
    logic out_free;
  } status_t;

endpackage

@@ src/tpqrc_ctrl.sv @@
// Sequencing state machine of the rate controller.
// Depends on tpqrc_pkg; drives tpqrc_dp through cmd_t and reads status_t.
module tpqrc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tpqrc_pkg::status_t status_i,
  output tpqrc_pkg::cmd_t    cmd_o
);

  tpqrc_pkg::state_e state_q, state_d;
  logic [tpqrc_pkg::CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpqrc_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      tpqrc_pkg::S_IDLE:   if (in_valid_i) state_d = tpqrc_pkg::S_CHECK;
      tpqrc_pkg::S_CHECK:  state_d = status_i.past_end ? tpqrc_pkg::S_DONE
                                                       : tpqrc_pkg::S_DINIT1;
      tpqrc_pkg::S_DINIT1: begin
        state_d = tpqrc_pkg::S_DIV1;
        cnt_d   = '0;
      end
      tpqrc_pkg::S_DIV1: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == tpqrc_pkg::DIV1_LAST) state_d = tpqrc_pkg::S_ACC;
      end
      tpqrc_pkg::S_ACC:    state_d = tpqrc_pkg::S_DQSEL;
      tpqrc_pkg::S_DQSEL: begin
        cnt_d   = '0;
        state_d = status_i.skip_div ? tpqrc_pkg::S_MUL2 : tpqrc_pkg::S_DIV2;
      end
      tpqrc_pkg::S_DIV2: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == tpqrc_pkg::DIV2_LAST) state_d = tpqrc_pkg::S_SQ;
      end
      tpqrc_pkg::S_SQ:     state_d = tpqrc_pkg::S_CLAMP;
      tpqrc_pkg::S_CLAMP:  state_d = tpqrc_pkg::S_MUL2;
      tpqrc_pkg::S_MUL2:   state_d = tpqrc_pkg::S_ROUND;
      tpqrc_pkg::S_ROUND:  state_d = tpqrc_pkg::S_DONE;
      tpqrc_pkg::S_DONE:   if (status_i.out_free) state_d = tpqrc_pkg::S_IDLE;
      default:             state_d = tpqrc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      tpqrc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      tpqrc_pkg::S_CHECK: begin
        cmd_o.mul1     = 1'b1;
        cmd_o.set_past = status_i.past_end;
      end
      tpqrc_pkg::S_DINIT1: cmd_o.div1_init = 1'b1;
      tpqrc_pkg::S_DIV1: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_shift = 1'b1;
      end
      tpqrc_pkg::S_ACC:   cmd_o.acc = 1'b1;
      tpqrc_pkg::S_DQSEL: begin
        cmd_o.dq_fixed  = status_i.skip_div;
        cmd_o.div2_init = !status_i.skip_div;
      end
      tpqrc_pkg::S_DIV2: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_shift = (cnt_q != '0);
      end
      tpqrc_pkg::S_SQ:    cmd_o.sq = 1'b1;
      tpqrc_pkg::S_CLAMP: cmd_o.clamp = 1'b1;
      tpqrc_pkg::S_MUL2:  cmd_o.mul2 = 1'b1;
      tpqrc_pkg::S_ROUND: cmd_o.round = 1'b1;
      tpqrc_pkg::S_DONE:  cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

endmodule

@@ src/tpqrc_dp.sv @@
// Datapath of the rate controller: totals, shared restoring divider, multipliers,
// rounding and the output word register. Depends on tpqrc_pkg.
module tpqrc_dp #(
  parameter int unsigned WarmupFrames = tpqrc_pkg::WARMUP_FRAMES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tpqrc_pkg::cmd_t      cmd_i,
  output tpqrc_pkg::status_t   status_o,
  input  tpqrc_pkg::in_word_t  in_data_i,
  input  logic [14:0]          base_quant_i,
  input  logic [23:0]          total_frames_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tpqrc_pkg::out_word_t out_data_o
);

  localparam int unsigned TW = tpqrc_pkg::TOT_W;
  localparam int unsigned NW = tpqrc_pkg::NUM_W;

  logic [23:0]   frame_q;
  logic [TW-1:0] exp_q, enc_q;
  logic [4:0]    cur_q;
  tpqrc_pkg::in_word_t item_q;
  logic [35:0]   prod_q;
  logic [tpqrc_pkg::Q18_W-1:0] q18_q;
  logic [TW:0]   rem_q;
  logic [NW-1:0] quo_q, num_q;
  logic [TW-1:0] dvs_q;
  logic [17:0]   sq_q;
  logic [tpqrc_pkg::DQ_W-1:0] dq_q;
  logic [tpqrc_pkg::Q34_W-1:0] q34_q;
  logic          out_valid_q;
  tpqrc_pkg::out_word_t res_q, out_q;

  logic [TW:0]   rem_sh, rem_nx;
  logic          ge;
  logic [46:0]   inc;
  logic [TW:0]   exp_sum, enc_sum;
  logic [23:0]   q18_clamped;
  logic [23:0]   hi_bound, lo_bound;
  logic          warm;
  logic [14:0]   dvs1;
  logic [37:0]   frac10, dith_sh;
  logic [7:0]    iq;
  logic [4:0]    iq_sat;

  assign rem_sh = cmd_i.div_shift ? {rem_q[TW-1:0], num_q[NW-1]} : rem_q;
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign rem_nx = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;

  assign dvs1    = (base_quant_i == '0) ? 15'd1 : base_quant_i;
  assign inc     = {16'd0, item_q.first_pass_other_bits} + {1'b0, quo_q};
  assign exp_sum = {1'b0, exp_q} + (TW+1)'(inc);
  assign enc_sum = {1'b0, enc_q} + (TW+1)'(item_q.coded_bits);

  assign hi_bound = {16'({1'b0, base_quant_i}) + 16'd5120, 8'd0};
  assign lo_bound = {1'b0, base_quant_i - 15'd10240, 8'd0};

  always_comb begin
    q18_clamped = q18_q;
    if (base_quant_i >= 15'd10240 && q18_q < lo_bound) q18_clamped = lo_bound;
    if (q18_clamped > hi_bound) q18_clamped = hi_bound;
  end

  assign warm = frame_q < 24'(WarmupFrames);
  assign status_o.past_end = frame_q >= total_frames_i;
  assign status_o.skip_div = warm || (exp_q == '0) || ({1'b0, enc_q} >= {exp_q, 1'b0});
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign frac10  = ({4'd0, q34_q[33:0]} << 3) + ({4'd0, q34_q[33:0]} << 1);
  assign dith_sh = {item_q.dither, 34'd0};
  assign iq      = {1'b0, q34_q[40:34]} + 8'(dith_sh < frac10);
  assign iq_sat  = (iq == 8'd0) ? 5'd1 : (iq > 8'd31) ? 5'd31 : iq[4:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q     <= '0;
      exp_q       <= '0;
      enc_q       <= '0;
      cur_q       <= 5'd1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.acc) begin
        frame_q <= frame_q + 24'd1;
        exp_q   <= exp_sum[TW] ? '1 : exp_sum[TW-1:0];
        enc_q   <= enc_sum[TW] ? '1 : enc_sum[TW-1:0];
      end
      if (cmd_i.round) cur_q <= iq_sat;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
    if (cmd_i.mul1) begin
      prod_q <= item_q.first_pass_texture_bits * item_q.first_pass_quant;
      q18_q  <= base_quant_i * item_q.next_multiplier;
    end
    if (cmd_i.div1_init) begin
      rem_q <= '0;
      num_q <= {prod_q, 10'd0};
      dvs_q <= TW'(dvs1);
      quo_q <= '0;
    end else if (cmd_i.div2_init) begin
      rem_q <= {1'b0, enc_q};
      num_q <= '0;
      dvs_q <= exp_q;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_nx;
      num_q <= {num_q[NW-2:0], 1'b0};
      quo_q <= {quo_q[NW-2:0], ge};
    end
    if (cmd_i.acc) q18_q <= q18_clamped;
    if (cmd_i.sq) sq_q <= 18'((34'(quo_q[16:0]) * 34'(quo_q[16:0])) >> 16);
    if (cmd_i.dq_fixed) dq_q <= warm ? tpqrc_pkg::DQ_ONE : tpqrc_pkg::DQ_MAX;
    else if (cmd_i.clamp) begin
      if (sq_q < 18'(tpqrc_pkg::DQ_MIN)) dq_q <= tpqrc_pkg::DQ_MIN;
      else if (sq_q > 18'(tpqrc_pkg::DQ_MAX)) dq_q <= tpqrc_pkg::DQ_MAX;
      else dq_q <= sq_q[16:0];
    end
    if (cmd_i.mul2) q34_q <= q18_q * dq_q;
    if (cmd_i.set_past) res_q <= '{quantizer: cur_q, past_end: 1'b1};
    else if (cmd_i.round) res_q <= '{quantizer: iq_sat, past_end: 1'b0};
    if (cmd_i.out_load) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/two_pass_quantizer_rate_control_top.sv @@
// Top level of the two-pass quantiser rate controller: APB registers, control, datapath.
// Depends on tpqrc_pkg, tpqrc_ctrl and tpqrc_dp.
//
//   channel   direction  handshake                 word
//   input     in         in_valid_i / in_ready_o   tpqrc_pkg::in_word_t
//   output    out        out_valid_o / out_ready_i tpqrc_pkg::out_word_t
//   config    in         psel/penable/pwrite       base_quant @0, total_frames @4
//
// A word runs through the bit-serial divider: 46 steps for the expected-bits quotient,
// then 17 for the coded/expected ratio, skipped in warmup or when the ratio is fixed.
// A word past the last frame skips both and returns the held quantiser.
// Reset clears the totals, the frame count and the handshake state.
// The next word is taken while a result waits on a stalled output.
module two_pass_quantizer_rate_control_top #(
  parameter int unsigned WarmupFrames = tpqrc_pkg::WARMUP_FRAMES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tpqrc_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tpqrc_pkg::out_word_t out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [14:0] base_q;
  logic [23:0] total_q;
  logic        wr_en;
  tpqrc_pkg::cmd_t    cmd;
  tpqrc_pkg::status_t status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= tpqrc_pkg::BASE_QUANT_RST;
      total_q <= tpqrc_pkg::TOTAL_FRAMES_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        tpqrc_pkg::REG_BASE_QUANT:   base_q  <= pwdata[14:0];
        tpqrc_pkg::REG_TOTAL_FRAMES: total_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tpqrc_pkg::REG_BASE_QUANT:   prdata = {17'd0, base_q};
      tpqrc_pkg::REG_TOTAL_FRAMES: prdata = {8'd0, total_q};
      default:                     prdata = '0;
    endcase
  end

  tpqrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tpqrc_dp #(
    .WarmupFrames (WarmupFrames)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .in_data_i      (in_data_i),
    .base_quant_i   (base_q),
    .total_frames_i (total_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o)
  );

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while one is in flight");

  a_quant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.quantizer != 5'd0)
    else $error("quantiser out of range");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !out_valid_o || out_ready_i)
    else $error("result overwrites an untaken word");

endmodule

@@ verif/two_pass_quantizer_rate_control_top_test.sv @@
// Testbench for two_pass_quantizer_rate_control_top: directed and random frame words
// checked against a scoreboard that predicts the next-frame quantiser.
// Depends on tpqrc_pkg and the RTL of the rate controller only.
module two_pass_quantizer_rate_control_top_test;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam logic [55:0] TOTAL_SAT = {56{1'b1}};
  localparam logic [2:0] ADDR_BASE_QUANT = {tpqrc_pkg::REG_BASE_QUANT, 2'b00};
  localparam logic [2:0] ADDR_TOTAL_FRAMES = {tpqrc_pkg::REG_TOTAL_FRAMES, 2'b00};

  class quant_scoreboard;
    logic [14:0] base_quant;
    logic [23:0] total_frames;
    logic [23:0] frame_index;
    logic [55:0] expected_total;
    logic [55:0] encoded_total;
    logic [4:0]  current_quant;
    tpqrc_pkg::out_word_t quant_q[$];
    int          errors;
    int          checked;
    int          past_end_seen;

    function new();
      base_quant     = tpqrc_pkg::BASE_QUANT_RST;
      total_frames   = tpqrc_pkg::TOTAL_FRAMES_RST;
      frame_index    = '0;
      expected_total = '0;
      encoded_total  = '0;
      current_quant  = 5'd1;
      errors         = 0;
      checked        = 0;
      past_end_seen  = 0;
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] value);
      if (addr == ADDR_BASE_QUANT) base_quant = value[14:0];
      else if (addr == ADDR_TOTAL_FRAMES) total_frames = value[23:0];
    endfunction

    function logic [55:0] sat_sum(logic [55:0] a, logic [63:0] b);
      logic [63:0] s;
      s = {8'd0, a} + b;
      return (s > {8'd0, TOTAL_SAT}) ? TOTAL_SAT : s[55:0];
    endfunction

    function logic [63:0] ratio_squared(logic [63:0] enc, logic [63:0] exb);
      logic [63:0] rem;
      logic [63:0] r;
      rem = enc;
      r = '0;
      if (enc >= 2 * exb) return 64'(tpqrc_pkg::DQ_MAX);
      if (rem >= exb) begin
        rem = rem - exb;
        r = 64'd1;
      end
      for (int i = 0; i < 16; i++) begin
        rem = rem << 1;
        r = r << 1;
        if (rem >= exb) begin
          rem = rem - exb;
          r[0] = 1'b1;
        end
      end
      return (r * r) >> 16;
    endfunction

    function void note_word(tpqrc_pkg::in_word_t w);
      tpqrc_pkg::out_word_t o;
      logic [63:0] divisor, inc, dq, q34, iq, frac;
      longint      q18, lo, hi;
      if (frame_index >= total_frames) begin
        o.quantizer = current_quant;
        o.past_end  = 1'b1;
        quant_q.push_back(o);
        return;
      end
      divisor = (base_quant == 0) ? 64'd1 : 64'(base_quant);
      inc = 64'(w.first_pass_other_bits) +
            (64'(w.first_pass_texture_bits) * 64'(w.first_pass_quant) * 64'd1024) / divisor;
      expected_total = sat_sum(expected_total, inc);
      encoded_total  = sat_sum(encoded_total, 64'(w.coded_bits));
      frame_index    = frame_index + 24'd1;
      q18 = longint'(base_quant) * longint'(w.next_multiplier);
      lo  = (longint'(base_quant) - 10240) * 256;
      hi  = (longint'(base_quant) + 5120) * 256;
      if (q18 < lo) q18 = lo;
      if (q18 > hi) q18 = hi;
      if (frame_index < tpqrc_pkg::WARMUP_FRAMES_DEF) dq = 64'(tpqrc_pkg::DQ_ONE);
      else if (expected_total == 0) dq = 64'(tpqrc_pkg::DQ_MAX);
      else begin
        dq = ratio_squared(64'(encoded_total), 64'(expected_total));
        if (dq < 64'(tpqrc_pkg::DQ_MIN)) dq = 64'(tpqrc_pkg::DQ_MIN);
        if (dq > 64'(tpqrc_pkg::DQ_MAX)) dq = 64'(tpqrc_pkg::DQ_MAX);
      end
      q34  = 64'(q18) * dq;
      iq   = q34 >> 34;
      frac = q34 & ((64'd1 << 34) - 1);
      if ((64'(w.dither) << 34) < frac * 10) iq++;
      if (iq < 1) iq = 64'd1;
      if (iq > 31) iq = 64'd31;
      current_quant = iq[4:0];
      o.quantizer = iq[4:0];
      o.past_end  = 1'b0;
      quant_q.push_back(o);
    endfunction

    function void check_word(tpqrc_pkg::out_word_t got);
      tpqrc_pkg::out_word_t want;
      if (quant_q.size() == 0) begin
        $display("%0t: unexpected word quantizer=%0d past_end=%0d", $time,
                 got.quantizer, got.past_end);
        errors++;
        return;
      end
      want = quant_q.pop_front();
      checked++;
      if (got.past_end) past_end_seen++;
      if (got.quantizer !== want.quantizer) begin
        $display("%0t: quantizer expected %0d got %0d", $time, want.quantizer, got.quantizer);
        errors++;
      end
      if (got.past_end !== want.past_end) begin
        $display("%0t: past_end expected %0d got %0d", $time, want.past_end, got.past_end);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  tpqrc_pkg::in_word_t  in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  tpqrc_pkg::out_word_t out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  quant_scoreboard sb;
  int unsigned cycles;
  int unsigned words_in;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_cycles;

  two_pass_quantizer_rate_control_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("two_pass_quantizer_rate_control_top test failed");
      $finish;
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_word(in_data_i);
      words_in <= words_in + 1;
    end
    if (rst_ni && out_valid_o && out_ready_i) sb.check_word(out_data_o);
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(addr, value);
  endtask

  task automatic send_word(tpqrc_pkg::in_word_t w);
    int unsigned seen;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    seen = words_in;
    do @(negedge clk_i); while (words_in == seen);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.quant_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [30:0] wide_rand();
    logic [30:0] v;
    v = 31'($urandom());
    return v >> $urandom_range(30);
  endfunction

  function automatic tpqrc_pkg::in_word_t make_word(int bias);
    tpqrc_pkg::in_word_t w;
    w.coded_bits = wide_rand();
    w.first_pass_texture_bits = wide_rand();
    w.first_pass_other_bits = wide_rand();
    w.first_pass_quant = 5'($urandom_range(31));
    w.next_multiplier = 9'(($urandom_range(3) == 0) ? $urandom_range(511)
                                                     : $urandom_range(128, 384));
    w.dither = 4'(($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(9));
    case (bias)
      1: w.coded_bits = w.coded_bits >> $urandom_range(8, 30);
      2: begin
        w.first_pass_texture_bits = w.first_pass_texture_bits >> $urandom_range(10, 30);
        w.first_pass_other_bits = w.first_pass_other_bits >> $urandom_range(10, 30);
      end
      3: begin
        w.first_pass_texture_bits = 31'(31'h7fff_ffff - $urandom_range(255));
        w.first_pass_quant = 5'd31;
        w.first_pass_other_bits = 31'h7fff_ffff;
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic run_phase(logic [14:0] base, logic [23:0] frames, int unsigned idle,
                           int unsigned stall, int bias, int count);
    drain();
    write_reg(ADDR_BASE_QUANT, 32'(base));
    write_reg(ADDR_TOTAL_FRAMES, 32'(frames));
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) send_word(make_word(bias));
  endtask

  initial begin
    tpqrc_pkg::in_word_t w;
    logic [8:0] mults[4];
    sb = new();
    cycles = 0;
    words_in = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mults = '{9'd0, 9'd128, 9'd384, 9'd511};
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    w = '0;
    w.coded_bits = 31'h7fff_ffff;
    w.first_pass_quant = 5'd31;
    w.next_multiplier = 9'd384;
    w.dither = 4'd9;
    send_word(w);
    send_word(w);

    drain();
    write_reg(ADDR_BASE_QUANT, 32'd0);
    write_reg(ADDR_TOTAL_FRAMES, 32'd40);
    for (int i = 0; i < 24; i++) begin
      w.coded_bits = i[0] ? 31'h7fff_ffff : 31'd0;
      w.first_pass_texture_bits = (i >= 20) ? 31'h7fff_ffff : 31'd0;
      w.first_pass_other_bits = (i >= 21) ? 31'h7fff_ffff : 31'd0;
      w.first_pass_quant = (i % 2) ? 5'd31 : 5'(i % 31);
      w.next_multiplier = mults[i % 4];
      w.dither = 4'(i);
      send_word(w);
    end

    run_phase(15'd1024, 24'hffffff, 0, 0, 0, 190);
    run_phase(15'd31744, 24'hffffff, 69, 0, 1, 95);
    drain();
    for (int i = 0; i < 95; i++) send_word(make_word(1));
    run_phase(15'd32767, 24'hffffff, 0, 69, 2, 0);
    hold_cycles = 600;
    for (int i = 0; i < 190; i++) send_word(make_word(2));
    run_phase(15'd1, 24'hffffff, 9, 9, 0, 190);
    run_phase(15'd0, 24'hffffff, 0, 0, 3, 190);
    run_phase(15'd4096, sb.frame_index + 24'd60, 69, 69, 0, 190);
    drain();

    $display("Covered %0d words over base_quant 0..32767 and total_frames 1..16777215,",
             words_in);
    $display("with warm-up, zero-expected, clamp and past-end cases (%0d past end).",
             sb.past_end_seen);
    if (sb.errors == 0 && sb.quant_q.size() == 0) begin
      $display("two_pass_quantizer_rate_control_top test passed");
    end else begin
      $display("two_pass_quantizer_rate_control_top test failed");
    end
    $finish;
  end

endmodule
